/* rtl/trace_edge_taper_window_unit_macros.svh */
// Assertion macros shared by the edge taper RTL.
`ifndef TRACE_EDGE_TAPER_WINDOW_UNIT_MACROS_SVH
`define TRACE_EDGE_TAPER_WINDOW_UNIT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define TETW_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("edge taper assertion failed");

// Condition implies consequence in the next cycle.
`define TETW_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("edge taper assertion failed");

`endif

/* rtl/tetw_pkg.sv */
// Shared types, constants and envelope table functions for the edge taper.
package tetw_pkg;

   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int ENV_TABLE_SIZE_DEF = 1024;
   localparam int MID_DEPTH          = 4;
   localparam int OUT_DEPTH          = 2;

   localparam logic [15:0] Q15_ONE = 16'h8000;

   // Shape codes.
   localparam logic [2:0] SHAPE_LINEAR = 3'd0;
   localparam logic [2:0] SHAPE_SINE   = 3'd1;
   localparam logic [2:0] SHAPE_COSINE = 3'd2;
   localparam logic [2:0] SHAPE_GAUSS1 = 3'd3;
   localparam logic [2:0] SHAPE_GAUSS2 = 3'd4;

   // Register indexes.
   localparam logic [2:0] CSR_TAPER_SHAPE  = 3'd0;
   localparam logic [2:0] CSR_TRACE_LEN    = 3'd1;
   localparam logic [2:0] CSR_START_LEN    = 3'd2;
   localparam logic [2:0] CSR_END_LEN      = 3'd3;
   localparam logic [2:0] CSR_FIRST_TRACES = 3'd4;
   localparam logic [2:0] CSR_LAST_TRACES  = 3'd5;
   localparam logic [2:0] CSR_TRACE_COUNT  = 3'd6;
   localparam logic [2:0] CSR_MIN_GAIN     = 3'd7;

   // Fixed-point constants of the envelope generator (Q2.30).
   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] Q30_PIH = 64'd1686629713;
   localparam logic [63:0] Q30_E1  = 64'd395007543;
   localparam logic [63:0] Q30_A1  = 64'd4089907518;
   localparam logic [63:0] Q30_A2  = 64'd2147483648;

   typedef struct packed {
      logic [2:0]  taper_shape;
      logic [15:0] trace_len;
      logic [15:0] start_len;
      logic [15:0] end_len;
      logic [15:0] first_traces;
      logic [15:0] last_traces;
      logic [15:0] trace_count;
      logic [15:0] min_gain;
   } cfg_type;

   // Classified sample: counters and which gain factors apply.
   // jobs: 0 first-trace, 1 last-trace, 2 start edge, 3 end edge.
   typedef struct packed {
      logic [15:0] position;
      logic [15:0] trace;
      logic        first_sample;
      logic        last_sample;
      logic [3:0]  jobs;
   } desc_type;

   typedef struct packed {
      logic        start;
      logic [15:0] index;
      logic [15:0] span;
      logic        trace_gain;
   } env_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] factor;
   } env_rsp_type;

   // Q1.15 product rounded half up.
   function automatic logic [15:0] mul15(logic [15:0] a, logic [15:0] b);
      logic [31:0] p;
      p = 32'(a) * 32'(b) + 32'd16384;
      return p[30:15];
   endfunction

   function automatic logic [15:0] q30_to_q15(logic [63:0] v);
      logic [63:0] r;
      r = (v + 64'd16384) >> 15;
      return (r > 64'(Q15_ONE)) ? Q15_ONE : r[15:0];
   endfunction

   // Sine in Q2.30 at phase q of a table of 2**lg entries.
   function automatic logic [63:0] sine_q30(int unsigned q, int unsigned lg);
      logic [63:0] x, x2, t;
      x  = (64'(q) * Q30_PIH) >> lg;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      return (x * t) >> 30;
   endfunction

   // Gaussian exp(-(a*(1-f))^2) in Q2.30.
   function automatic logic [63:0] gauss_q30(int unsigned q, int unsigned lg,
                                            logic [63:0] a);
      logic [63:0] u, y, n, r, t;
      u = (a * (64'(1 << lg) - 64'(q))) >> lg;
      y = (u * u) >> 30;
      n = y >> 30;
      r = y & (Q30_ONE - 64'd1);
      t = Q30_ONE;
      t = Q30_ONE - ((r * t) >> 30) / 10;
      t = Q30_ONE - ((r * t) >> 30) / 9;
      t = Q30_ONE - ((r * t) >> 30) / 8;
      t = Q30_ONE - ((r * t) >> 30) / 7;
      t = Q30_ONE - ((r * t) >> 30) / 6;
      t = Q30_ONE - ((r * t) >> 30) / 5;
      t = Q30_ONE - ((r * t) >> 30) / 4;
      t = Q30_ONE - ((r * t) >> 30) / 3;
      t = Q30_ONE - ((r * t) >> 30) / 2;
      t = Q30_ONE - ((r * t) >> 30);
      for (int k = 0; k < 64; k++) begin
         if (64'(k) < n) begin
            t = (t * Q30_E1 + (Q30_ONE >> 1)) >> 30;
         end
      end
      return t;
   endfunction

   // Q1.15 envelope table entry for the non-linear shapes.
   function automatic logic [15:0] env_q15(logic [2:0] shape, int unsigned q,
                                           int unsigned lg);
      logic [63:0] s;
      case (shape)
         SHAPE_SINE:   return q30_to_q15(sine_q30(q, lg));
         SHAPE_COSINE: begin
            s = sine_q30(q, lg);
            return q30_to_q15((s * s + (Q30_ONE >> 1)) >> 30);
         end
         SHAPE_GAUSS1: return q30_to_q15(gauss_q30(q, lg, Q30_A1));
         SHAPE_GAUSS2: return q30_to_q15(gauss_q30(q, lg, Q30_A2));
         default:      return 16'd0;
      endcase
   endfunction

endpackage

/* rtl/trace_edge_taper_window_unit.sv */
// Edge taper top level: configuration registers, front end, queues, back end.
// Each sample is handled in turn: the back end requests one envelope factor per active gain
// factor and takes the next sample only after the result of the last one is pushed.
// Throughput is set by the shared envelope unit, whose divider yields one bit a cycle.
// Reset (synchronous, active high) restores register defaults, clears counters,
// empties the queues and sets the trace gain to one.
module trace_edge_taper_window_unit #(
   parameter int SAMPLE_BITS    = tetw_pkg::SAMPLE_BITS_DEF,
   parameter int ENV_TABLE_SIZE = tetw_pkg::ENV_TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_trace_end,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [15:0]                   csr_wdata
);
   import tetw_pkg::*;

`include "trace_edge_taper_window_unit_macros.svh"

   localparam int MW = SAMPLE_BITS + $bits(desc_type);

   cfg_type     cfg_ff;
   desc_type    front_desc, mid_desc;
   logic [MW-1:0] mid_out;
   logic        accept, mid_empty, mid_pop, out_push, out_full;
   logic [SAMPLE_BITS:0] out_data, rsp_data;
   env_req_type env_req;
   env_rsp_type env_rsp;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.taper_shape  <= SHAPE_LINEAR;
         cfg_ff.trace_len    <= 16'd1024;
         cfg_ff.start_len    <= '0;
         cfg_ff.end_len      <= '0;
         cfg_ff.first_traces <= '0;
         cfg_ff.last_traces  <= '0;
         cfg_ff.trace_count  <= 16'd1;
         cfg_ff.min_gain     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAPER_SHAPE:  cfg_ff.taper_shape  <= csr_wdata[2:0];
            CSR_TRACE_LEN:    cfg_ff.trace_len    <= csr_wdata;
            CSR_START_LEN:    cfg_ff.start_len    <= csr_wdata;
            CSR_END_LEN:      cfg_ff.end_len      <= csr_wdata;
            CSR_FIRST_TRACES: cfg_ff.first_traces <= csr_wdata;
            CSR_LAST_TRACES:  cfg_ff.last_traces  <= csr_wdata;
            CSR_TRACE_COUNT:  cfg_ff.trace_count  <= csr_wdata;
            CSR_MIN_GAIN:     cfg_ff.min_gain     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept = req_push && !req_full;

   tetw_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .desc   (front_desc)
   );

   // Queue of classified beats between front and back.
   tetw_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .data_in  ({req_sample_in, front_desc}),
      .full     (req_full),
      .pop      (mid_pop),
      .data_out (mid_out),
      .empty    (mid_empty)
   );

   assign mid_desc = mid_out[$bits(desc_type)-1:0];

   tetw_env #(.ENV_TABLE_SIZE(ENV_TABLE_SIZE)) u_env (
      .clock    (clock),
      .reset    (reset),
      .shape    (cfg_ff.taper_shape),
      .min_gain (cfg_ff.min_gain),
      .req      (env_req),
      .rsp      (env_rsp)
   );

   tetw_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .mid_desc   (mid_desc),
      .mid_sample (mid_out[MW-1:$bits(desc_type)]),
      .mid_empty  (mid_empty),
      .mid_pop    (mid_pop),
      .env_req    (env_req),
      .env_rsp    (env_rsp),
      .out_push   (out_push),
      .out_data   (out_data),
      .out_full   (out_full)
   );

   // Result queue toward the consumer.
   tetw_fifo #(.WIDTH(SAMPLE_BITS + 1), .DEPTH(OUT_DEPTH)) u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .data_in  (out_data),
      .full     (out_full),
      .pop      (rsp_pop),
      .data_out (rsp_data),
      .empty    (rsp_empty)
   );

   assign rsp_sample_out = rsp_data[SAMPLE_BITS:1];
   assign rsp_trace_end  = rsp_data[0];

   // An accepted beat is waiting in the middle queue on the next cycle.
   `TETW_ASSERT_NEXT(a_mid_holds_beat, clock, reset, accept, !mid_empty)
   // The back end pushes a result only into a queue with room.
   `TETW_ASSERT_NOW(a_out_room, clock, reset, out_push, !out_full)
   // An envelope start is never answered with done straight away.
   `TETW_ASSERT_NEXT(a_env_answer, clock, reset, env_req.start, !env_rsp.done)
endmodule

/* rtl/tetw_fifo.sv */
// Small first-in first-out queue with full and empty flags.
module tetw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem[rd_ptr_ff];

   // Storage is written at the tail.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= data_in;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

/* rtl/tetw_front.sv */
// Front end: tracks sample and trace position and classifies each beat.
module tetw_front (
   input  logic               clock,
   input  logic               reset,
   input  tetw_pkg::cfg_type  cfg,
   input  logic               accept,
   output tetw_pkg::desc_type desc
);
   import tetw_pkg::*;

   logic [15:0] pos_ff, pos_in, trc_ff, trc_in;
   logic [15:0] len, cnt, end_idx, last_idx;
   logic [16:0] pos_inc, trc_inc;
   logic        last;

   assign len      = (cfg.trace_len == '0) ? 16'd1 : cfg.trace_len;
   assign cnt      = (cfg.trace_count == '0) ? 16'd1 : cfg.trace_count;
   assign pos_inc  = {1'b0, pos_ff} + 17'd1;
   assign trc_inc  = {1'b0, trc_ff} + 17'd1;
   assign last     = (pos_inc >= {1'b0, len});
   assign end_idx  = len - 16'd1 - pos_ff;
   assign last_idx = cnt - 16'd1 - trc_ff;

   // Decide which gain factors this sample needs.
   always_comb begin
      desc.position     = pos_ff;
      desc.trace        = trc_ff;
      desc.first_sample = (pos_ff == '0);
      desc.last_sample  = last;
      desc.jobs[0] = desc.first_sample && (trc_ff < cfg.first_traces);
      desc.jobs[1] = desc.first_sample && (trc_ff < cnt) && (last_idx < cfg.last_traces);
      desc.jobs[2] = (cfg.start_len > 16'd1) && (pos_ff < cfg.start_len);
      desc.jobs[3] = (cfg.end_len > 16'd1) && (pos_ff < len) && (end_idx < cfg.end_len);
   end

   // Next counter values.
   always_comb begin
      pos_in = pos_ff;
      trc_in = trc_ff;
      if (accept) begin
         if (last) begin
            pos_in = '0;
            trc_in = (trc_inc >= {1'b0, cnt}) ? 16'd0 : trc_inc[15:0];
         end else begin
            pos_in = pos_inc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         trc_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         trc_ff <= trc_in;
      end
   end
endmodule

/* rtl/tetw_env.sv */
// Envelope unit: phase division, shape table lookup and trace gain floor.
module tetw_env #(
   parameter int ENV_TABLE_SIZE = tetw_pkg::ENV_TABLE_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            shape,
   input  logic [15:0]           min_gain,
   input  tetw_pkg::env_req_type req,
   output tetw_pkg::env_rsp_type rsp
);
   import tetw_pkg::*;

   localparam int LG = $clog2(ENV_TABLE_SIZE);
   localparam int CW = $clog2(LG + 1);

   typedef logic [15:0] rom_type [ENV_TABLE_SIZE];

   function automatic rom_type build_rom(logic [2:0] s);
      rom_type r;
      for (int i = 0; i < ENV_TABLE_SIZE; i++) begin
         r[i] = env_q15(s, i, LG);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM   = build_rom(SHAPE_SINE);
   localparam rom_type COSINE_ROM = build_rom(SHAPE_COSINE);
   localparam rom_type GAUSS1_ROM = build_rom(SHAPE_GAUSS1);
   localparam rom_type GAUSS2_ROM = build_rom(SHAPE_GAUSS2);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_ROM, ST_SEL} state_type;

   state_type   state_ff;
   logic [15:0] rem_ff, n_ff, rd_ff;
   logic [LG-1:0] q_ff;
   logic [CW-1:0] cnt_ff;
   logic        trace_ff;
   env_rsp_type rsp_ff;

   logic [16:0] rem2, rem_sub;
   logic        ge, is_linear;
   logic [15:0] lin_env, env, m_eff, factor;
   logic [31:0] lin_wide;

   // One restoring division step per cycle.
   assign rem2    = {rem_ff, 1'b0};
   assign rem_sub = rem2 - {1'b0, n_ff};
   assign ge      = (rem2 >= {1'b0, n_ff});

   // Envelope select and the linear trace gain floor.
   assign is_linear = !(shape == SHAPE_SINE || shape == SHAPE_COSINE ||
                        shape == SHAPE_GAUSS1 || shape == SHAPE_GAUSS2);
   assign lin_wide  = (32'(q_ff) << 15) >> LG;
   assign lin_env   = lin_wide[15:0];
   assign env       = is_linear ? lin_env : rd_ff;
   assign m_eff     = (min_gain > Q15_ONE) ? Q15_ONE : min_gain;
   assign factor    = (is_linear && trace_ff) ? m_eff + mul15(Q15_ONE - m_eff, env) : env;

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req.start) begin
                  rem_ff   <= req.index;
                  n_ff     <= req.span;
                  trace_ff <= req.trace_gain;
                  q_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= ge ? rem_sub[15:0] : rem2[15:0];
               q_ff   <= {q_ff[LG-2:0], ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(LG - 1)) begin
                  state_ff <= ST_ROM;
               end
            end
            ST_ROM: begin
               case (shape)
                  SHAPE_SINE:   rd_ff <= SINE_ROM[q_ff];
                  SHAPE_COSINE: rd_ff <= COSINE_ROM[q_ff];
                  SHAPE_GAUSS1: rd_ff <= GAUSS1_ROM[q_ff];
                  SHAPE_GAUSS2: rd_ff <= GAUSS2_ROM[q_ff];
                  default:      rd_ff <= '0;
               endcase
               state_ff <= ST_SEL;
            end
            ST_SEL: begin
               rsp_ff.done   <= 1'b1;
               rsp_ff.factor <= factor;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

/* rtl/tetw_back.sv */
// Back end: sequences the gain factors of a sample and applies the gain.
module tetw_back #(
   parameter int SAMPLE_BITS = tetw_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tetw_pkg::cfg_type      cfg,
   input  tetw_pkg::desc_type     mid_desc,
   input  logic [SAMPLE_BITS-1:0] mid_sample,
   input  logic                   mid_empty,
   output logic                   mid_pop,
   output tetw_pkg::env_req_type  env_req,
   input  tetw_pkg::env_rsp_type  env_rsp,
   output logic                   out_push,
   output logic [SAMPLE_BITS:0]   out_data,
   input  logic                   out_full
);
   import tetw_pkg::*;

   localparam int PW = SAMPLE_BITS + 17;
   localparam logic signed [PW-1:0] YMAX = PW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [PW-1:0] YMIN = -PW'(longint'(1) << (SAMPLE_BITS - 1));

   typedef enum logic [2:0] {
      ST_FETCH, ST_NEXT, ST_WAIT, ST_MUL, ST_GAIN, ST_PROD, ST_OUT
   } state_type;

   state_type   state_ff;
   desc_type    desc_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [2:0]  job_ff;
   logic        tg_pend_ff;
   logic [15:0] acc_ff, tgain_ff, factor_ff, g_ff;
   logic signed [PW-1:0] prod_ff;
   env_req_type req_ff;

   logic [15:0] len, cnt, job_index, job_span;
   logic        job_trace;
   logic signed [PW-1:0] rnd, shifted, sat;

   assign len = (cfg.trace_len == '0) ? 16'd1 : cfg.trace_len;
   assign cnt = (cfg.trace_count == '0) ? 16'd1 : cfg.trace_count;

   // Phase index and span of the current factor.
   always_comb begin
      job_trace = 1'b0;
      case (job_ff[1:0])
         2'd0: begin
            job_index = desc_ff.trace;
            job_span  = cfg.first_traces;
            job_trace = 1'b1;
         end
         2'd1: begin
            job_index = cnt - 16'd1 - desc_ff.trace;
            job_span  = cfg.last_traces;
            job_trace = 1'b1;
         end
         2'd2: begin
            job_index = desc_ff.position;
            job_span  = cfg.start_len;
         end
         default: begin
            job_index = len - 16'd1 - desc_ff.position;
            job_span  = cfg.end_len;
         end
      endcase
   end

   // Rounding of the final product and saturation.
   assign rnd      = prod_ff + PW'(16384);
   assign shifted  = rnd >>> 15;
   assign sat      = (shifted > YMAX) ? YMAX : ((shifted < YMIN) ? YMIN : shifted);

   assign mid_pop  = (state_ff == ST_FETCH) && !mid_empty;
   assign out_push = (state_ff == ST_OUT) && !out_full;
   assign out_data = {sat[SAMPLE_BITS-1:0], desc_ff.last_sample};
   assign env_req  = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         req_ff.start <= 1'b0;
         tgain_ff     <= Q15_ONE;
         tg_pend_ff   <= 1'b0;
      end else begin
         req_ff.start <= 1'b0;
         unique case (state_ff)
            ST_FETCH: begin
               if (!mid_empty) begin
                  desc_ff    <= mid_desc;
                  x_ff       <= mid_sample;
                  acc_ff     <= Q15_ONE;
                  job_ff     <= '0;
                  tg_pend_ff <= mid_desc.first_sample;
                  state_ff   <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (job_ff == 3'd2 && tg_pend_ff) begin
                  // Trace factors are done: keep them as this trace's gain.
                  tgain_ff   <= acc_ff;
                  acc_ff     <= Q15_ONE;
                  tg_pend_ff <= 1'b0;
               end else if (job_ff == 3'd4) begin
                  state_ff <= ST_GAIN;
               end else if (desc_ff.jobs[job_ff[1:0]]) begin
                  req_ff.start      <= 1'b1;
                  req_ff.index      <= job_index;
                  req_ff.span       <= job_span;
                  req_ff.trace_gain <= job_trace;
                  state_ff          <= ST_WAIT;
               end else begin
                  job_ff <= job_ff + 3'd1;
               end
            end
            ST_WAIT: begin
               if (env_rsp.done) begin
                  factor_ff <= env_rsp.factor;
                  state_ff  <= ST_MUL;
               end
            end
            ST_MUL: begin
               acc_ff   <= mul15(acc_ff, factor_ff);
               job_ff   <= job_ff + 3'd1;
               state_ff <= ST_NEXT;
            end
            ST_GAIN: begin
               g_ff     <= mul15(acc_ff, tgain_ff);
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               prod_ff  <= PW'(x_ff) * PW'($signed({1'b0, g_ff}));
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!out_full) begin
                  state_ff <= ST_FETCH;
               end
            end
            default: state_ff <= ST_FETCH;
         endcase
      end
   end
endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the trace edge taper unit: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
   import tetw_pkg::*;

   localparam int SB         = 24;
   localparam int TABLE_SIZE = 1024;
   localparam int SETTLE     = 100;
   localparam int STALL_MAX  = 20000;

   typedef logic signed [SB-1:0] sample_t;

   typedef struct {
      sample_t sample_out;
      logic    trace_end;
   } taper_beat_t;

   typedef struct {
      bit          is_write;
      logic [2:0]  idx;
      logic [15:0] val;
      sample_t     smp;
      bit          typed;
      sample_t     typed_out;
      bit          typed_end;
   } row_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   sample_t     req_sample_in = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   sample_t     rsp_sample_out;
   logic        rsp_trace_end;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Shadow of the configuration and the taper state.
   logic [2:0]  m_shape;
   logic [15:0] m_len, m_start, m_end, m_first, m_last, m_count, m_min;
   logic [15:0] m_pos, m_trace, m_tgain;

   taper_beat_t tapered_q[$];
   row_t        rows[$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          tx_idle = 1'b1;
   bit          rx_idle = 1'b1;
   int          rx_hold = 0;

   trace_edge_taper_window_unit dut (.*);

   // Free-running clock, 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog: too long without any beat ends the run.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [15:0] q15_mul(logic [15:0] a, logic [15:0] b);
      bit [63:0] p;
      p = (64'(a) * 64'(b) + 64'd16384) >> 15;
      return p[15:0];
   endfunction

   function automatic logic [15:0] to_q15(bit [63:0] v);
      bit [63:0] r;
      r = (v + 64'd16384) >> 15;
      return (r > 64'd32768) ? 16'h8000 : r[15:0];
   endfunction

   function automatic bit [63:0] sine_fix(int unsigned q);
      bit [63:0] x, x2, t;
      int unsigned dv[5];
      dv = '{110, 72, 42, 20, 6};
      x  = (64'(q) * Q30_PIH) / TABLE_SIZE;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int k = 0; k < 5; k++) t = Q30_ONE - ((x2 * t) >> 30) / dv[k];
      return (x * t) >> 30;
   endfunction

   function automatic bit [63:0] gauss_fix(int unsigned q, bit [63:0] a);
      bit [63:0] u, y, n, r, t;
      u = (a * 64'(TABLE_SIZE - q)) / TABLE_SIZE;
      y = (u * u) >> 30;
      n = y >> 30;
      r = y & (Q30_ONE - 64'd1);
      t = Q30_ONE;
      for (int k = 10; k >= 1; k--) t = Q30_ONE - ((r * t) >> 30) / k;
      while (n > 0) begin
         t = (t * Q30_E1 + (Q30_ONE >> 1)) >> 30;
         n--;
      end
      return t;
   endfunction

   // Envelope at phase i/n, quantized to the table.
   function automatic logic [15:0] envelope_at(int unsigned i, int unsigned n);
      int unsigned q;
      bit [63:0]   s;
      q = int'((64'(i) * TABLE_SIZE) / n);
      if (q >= TABLE_SIZE) q = TABLE_SIZE - 1;
      case (m_shape)
         SHAPE_SINE:   return to_q15(sine_fix(q));
         SHAPE_COSINE: begin
            s = sine_fix(q);
            return to_q15((s * s + (Q30_ONE >> 1)) >> 30);
         end
         SHAPE_GAUSS1: return to_q15(gauss_fix(q, Q30_A1));
         SHAPE_GAUSS2: return to_q15(gauss_fix(q, Q30_A2));
         default:      return 16'((q << 15) / TABLE_SIZE);
      endcase
   endfunction

   // One trace-gain factor; the linear family is lifted by the minimum gain.
   function automatic logic [15:0] panel_factor(int unsigned i, int unsigned n);
      int unsigned e, m;
      e = envelope_at(i, n);
      m = (m_min > 16'h8000) ? 32768 : m_min;
      if (m_shape != SHAPE_LINEAR && m_shape <= SHAPE_GAUSS2) return 16'(e);
      return 16'(m + ((64'(32768 - m) * e + 64'd16384) >> 15));
   endfunction

   function automatic logic [15:0] panel_gain();
      int unsigned cnt, j;
      logic [15:0] g;
      cnt = (m_count != 0) ? m_count : 1;
      g   = Q15_ONE;
      if (m_trace < m_first) g = q15_mul(g, panel_factor(m_trace, m_first));
      if (m_trace < cnt) begin
         j = cnt - 1 - m_trace;
         if (j < m_last) g = q15_mul(g, panel_factor(j, m_last));
      end
      return g;
   endfunction

   // Advance the shadow state by one sample and return the tapered beat.
   function automatic taper_beat_t taper_sample(sample_t s);
      taper_beat_t b;
      int unsigned len, cnt, p, i;
      logic [15:0] tg, g;
      longint      y;
      len = (m_len != 0) ? m_len : 1;
      cnt = (m_count != 0) ? m_count : 1;
      p   = m_pos;
      if (p == 0) m_tgain = panel_gain();
      tg = Q15_ONE;
      if (m_start > 1 && p < m_start) tg = q15_mul(tg, envelope_at(p, m_start));
      if (m_end > 1 && p < len) begin
         i = len - 1 - p;
         if (i < m_end) tg = q15_mul(tg, envelope_at(i, m_end));
      end
      g = q15_mul(tg, m_tgain);
      y = (longint'(s) * longint'(g) + 64'sd16384) >>> 15;
      if (y < -(64'sd1 <<< (SB - 1))) y = -(64'sd1 <<< (SB - 1));
      if (y > (64'sd1 <<< (SB - 1)) - 1) y = (64'sd1 <<< (SB - 1)) - 1;
      b.sample_out = y[SB-1:0];
      b.trace_end  = (p + 1 >= len);
      if (b.trace_end) begin
         m_pos   = '0;
         m_trace = (m_trace + 1 >= cnt) ? 16'd0 : m_trace + 16'd1;
      end else begin
         m_pos = m_pos + 16'd1;
      end
      return b;
   endfunction

   // Register write; the enable is lowered by the next sample beat.
   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_TAPER_SHAPE:  m_shape = val[2:0];
         CSR_TRACE_LEN:    m_len   = val;
         CSR_START_LEN:    m_start = val;
         CSR_END_LEN:      m_end   = val;
         CSR_FIRST_TRACES: m_first = val;
         CSR_LAST_TRACES:  m_last  = val;
         CSR_TRACE_COUNT:  m_count = val;
         default:          m_min   = val;
      endcase
   endtask

   // Offer one sample after a random gap and record its expected beat.
   task automatic send_sample(sample_t s, bit typed, sample_t t_out, bit t_end);
      int gap;
      taper_beat_t b;
      gap    = tx_idle ? $urandom_range(0, 10) : 0;
      csr_we <= 1'b0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (req_full);
      b = taper_sample(s);
      if (typed) begin
         b.sample_out = t_out;
         b.trace_end  = t_end;
      end
      tapered_q.push_back(b);
   endtask

   // Stop offering and wait until every beat is back and the pipe is quiet.
   task automatic drain();
      req_push <= 1'b0;
      csr_we   <= 1'b0;
      do @(posedge clock); while (tapered_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add_write(logic [2:0] idx, logic [15:0] val);
      row_t r;
      r = '{1'b1, idx, val, '0, 1'b0, '0, 1'b0};
      rows.push_back(r);
   endtask

   task automatic add_sample(sample_t s, bit typed, sample_t t_out, bit t_end);
      row_t r;
      r = '{1'b0, CSR_TAPER_SHAPE, 16'd0, s, typed, t_out, t_end};
      rows.push_back(r);
   endtask

   // Receiver: random stalls, one long hold-off on request, field checks.
   initial begin
      int stall;
      taper_beat_t want;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = rx_idle ? $urandom_range(0, 10) : 0;
         if (rx_hold > 0) begin
            stall   = rx_hold;
            rx_hold = 0;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (tapered_q.size() == 0) begin
            report("unexpected beat", rsp_sample_out, 0);
         end else begin
            want = tapered_q.pop_front();
            if (rsp_sample_out !== want.sample_out)
               report("sample_out", rsp_sample_out, want.sample_out);
            if (rsp_trace_end !== want.trace_end)
               report("trace_end", rsp_trace_end, want.trace_end);
         end
      end
   end

   // Main sequence.
   initial begin
      bit prev_sample;
      int len, cnt;
      logic [15:0] mg;
      m_shape = SHAPE_LINEAR;
      m_len = 16'd1024; m_start = '0; m_end = '0; m_first = '0; m_last = '0;
      m_count = 16'd1; m_min = '0;
      m_pos = '0; m_trace = '0; m_tgain = Q15_ONE;

      // Reset defaults give unity gain, so the extremes and the other samples come back unchanged.
      add_sample(24'sh7FFFFF, 1, 24'sh7FFFFF, 0);
      add_sample(-24'sh800000, 1, -24'sh800000, 0);
      add_sample(24'sh000000, 1, 24'sh000000, 0);
      add_sample(-24'sh000001, 1, -24'sh000001, 0);
      add_sample(24'sh000001, 1, 24'sh000001, 0);
      add_sample(24'sh2AAAAA, 1, 24'sh2AAAAA, 0);
      // Short traces with both edges and both panel tapers active.
      add_write(CSR_TAPER_SHAPE, 16'(SHAPE_SINE));
      add_write(CSR_TRACE_LEN, 16'd4);
      add_write(CSR_START_LEN, 16'd2);
      add_write(CSR_END_LEN, 16'd3);
      add_write(CSR_FIRST_TRACES, 16'd2);
      add_write(CSR_LAST_TRACES, 16'd2);
      add_write(CSR_TRACE_COUNT, 16'd3);
      add_write(CSR_MIN_GAIN, 16'd0);
      for (int k = 0; k < 6; k++) add_sample(24'sh7FFFFF - k, 0, '0, 0);
      // Unknown shape, oversized minimum gain, zero length and zero count.
      add_write(CSR_TAPER_SHAPE, 16'd7);
      add_write(CSR_MIN_GAIN, 16'd40000);
      add_write(CSR_TRACE_LEN, 16'd0);
      add_write(CSR_TRACE_COUNT, 16'd0);
      for (int k = 0; k < 3; k++) add_sample(-24'sh7FFFF0 + k, 0, '0, 0);
      // Trace index left beyond a shrunken trace count.
      add_write(CSR_MIN_GAIN, 16'd1000);
      add_write(CSR_TRACE_LEN, 16'd1);
      add_write(CSR_TRACE_COUNT, 16'd6);
      for (int k = 0; k < 4; k++) add_sample(24'sh400000 + k, 0, '0, 0);
      add_write(CSR_TRACE_COUNT, 16'd2);
      add_write(CSR_TRACE_LEN, 16'd8);
      for (int k = 0; k < 5; k++) add_sample(-24'sh123456 - k, 0, '0, 0);
      // Sample position left beyond a shrunken trace length.
      add_write(CSR_TRACE_LEN, 16'd3);
      for (int k = 0; k < 3; k++) add_sample(24'sh654321 + k, 0, '0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      prev_sample = 1'b0;
      foreach (rows[n]) begin
         if (rows[n].is_write) begin
            if (prev_sample) drain();
            csr_write(rows[n].idx, rows[n].val);
            prev_sample = 1'b0;
         end else begin
            send_sample(rows[n].smp, rows[n].typed, rows[n].typed_out, rows[n].typed_end);
            prev_sample = 1'b1;
         end
      end
      drain();

      // Random phases; the first three use extreme settings.
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 0) begin
            csr_write(CSR_TAPER_SHAPE, 16'd7);
            for (int r = 1; r < 8; r++) csr_write(3'(r), 16'hFFFF);
         end else if (ph == 1) begin
            csr_write(CSR_TAPER_SHAPE, 16'(SHAPE_LINEAR));
            csr_write(CSR_TRACE_LEN, 16'd1);
            csr_write(CSR_START_LEN, 16'd0);
            csr_write(CSR_END_LEN, 16'd0);
            csr_write(CSR_FIRST_TRACES, 16'd0);
            csr_write(CSR_LAST_TRACES, 16'd0);
            csr_write(CSR_TRACE_COUNT, 16'd1);
            csr_write(CSR_MIN_GAIN, 16'd0);
         end else begin
            len = (ph == 2) ? 0 : $urandom_range(1, 40);
            cnt = (ph == 2) ? 0 : $urandom_range(1, 8);
            case ($urandom_range(0, 2))
               0:       mg = 16'd0;
               1:       mg = 16'h8000;
               default: mg = 16'($urandom);
            endcase
            csr_write(CSR_TAPER_SHAPE, 16'(ph % 8));
            csr_write(CSR_TRACE_LEN, 16'(len));
            csr_write(CSR_START_LEN, 16'($urandom_range(0, len + 4)));
            csr_write(CSR_END_LEN, 16'($urandom_range(0, len + 4)));
            csr_write(CSR_FIRST_TRACES, 16'($urandom_range(0, cnt + 2)));
            csr_write(CSR_LAST_TRACES, 16'($urandom_range(0, cnt + 2)));
            csr_write(CSR_TRACE_COUNT, 16'(cnt));
            csr_write(CSR_MIN_GAIN, mg);
         end
         // Alternate idling patterns; one phase backs up the whole block.
         tx_idle = (ph % 3) != 1;
         rx_idle = (ph % 4) != 2;
         if (ph == 3) begin
            tx_idle = 1'b0;
            rx_hold = 400;
         end
         for (int k = 0; k < 160; k++) send_sample(sample_t'($urandom), 0, '0, 0);
         drain();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
